/* src/sot_pkg.sv */
`default_nettype none

package sot_pkg;

    localparam int COORD_BITS_DEF = 16;

    localparam logic KIND_RECT   = 1'b0;
    localparam logic KIND_CIRCLE = 1'b1;

    localparam int KIND_BITS   = 2;
    localparam int RESULT_BITS = 8;

endpackage

`default_nettype wire

/* src/sot_axis.sv */
`default_nettype none

// gap along one axis between spans [pos_a, pos_a+len_a] and [pos_b, pos_b+len_b],
// squared; a circle enters as a point (length zero)
module sot_axis #(
    parameter int COORD_BITS = sot_pkg::COORD_BITS_DEF
) (
    input  wire logic signed [COORD_BITS-1:0]   pos_a,
    input  wire logic        [COORD_BITS-2:0]   len_a,
    input  wire logic signed [COORD_BITS-1:0]   pos_b,
    input  wire logic        [COORD_BITS-2:0]   len_b,
    output logic             [2*COORD_BITS-1:0] gap_sq,
    output logic                                gap_zero
);

    localparam int W = COORD_BITS + 2;

    logic signed [W-1:0]          pa_ext;
    logic signed [W-1:0]          pb_ext;
    logic signed [W-1:0]          end_a;
    logic signed [W-1:0]          end_b;
    logic signed [W-1:0]          d_ab;
    logic signed [W-1:0]          d_ba;
    logic                         ab_pos;
    logic                         ba_pos;
    logic        [COORD_BITS-1:0] gap;

    always_comb
    begin
        pa_ext = {{2{pos_a[COORD_BITS-1]}}, pos_a};
        pb_ext = {{2{pos_b[COORD_BITS-1]}}, pos_b};
        end_a  = pa_ext + $signed({3'b000, len_a});
        end_b  = pb_ext + $signed({3'b000, len_b});
        d_ab   = pb_ext - end_a;
        d_ba   = pa_ext - end_b;
        ab_pos = !d_ab[W-1] && (d_ab != '0);
        ba_pos = !d_ba[W-1] && (d_ba != '0);
        if (ab_pos)
        begin
            gap = d_ab[COORD_BITS-1:0];
        end
        else if (ba_pos)
        begin
            gap = d_ba[COORD_BITS-1:0];
        end
        else
        begin
            gap = '0;
        end
    end

    assign gap_sq   = gap * gap;
    assign gap_zero = !(ab_pos || ba_pos);

endmodule

`default_nettype wire

/* src/shape_overlap_test.sv */
// shape_overlap_test: overlap test for two 2-D shapes, one pair per request.
// Input channel s_*: one request carries two shapes, each a rectangle
// (left/top corner, width, height) or a circle (centre, radius), Q12.4.
// s_tuser holds the two kind bits (0 rectangle, 1 circle).
// Output channel m_*: one request per input request, bit 0 of m_tdata is 1
// when the shapes overlap or touch.
// Two register stages (input register, result register): a request accepted
// into the input register is presented on m_* from the result register.
// Throughput: one request per cycle while m_tready is high; the per-axis gap
// squares, radius square and final compare sit between the two registers.
// Reset (rst_n low, asynchronous) empties both stages; no request is
// presented until a new one is accepted.
// When the receiver holds m_tready low the result register holds its
// request, the input register still takes one more request, and s_tready
// falls only when both stages are full.
`default_nettype none

module shape_overlap_test #(
    parameter int COORD_BITS = sot_pkg::COORD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // first_x, first_y, first_extent_a, first_extent_b,
    // second_x, second_y, second_extent_a, second_extent_b, zero fill
    input  wire logic [((8*COORD_BITS-4+7)/8)*8-1:0] s_tdata,
    // first_kind, second_kind
    input  wire logic [sot_pkg::KIND_BITS-1:0]       s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // overlapping, zero fill
    output logic [sot_pkg::RESULT_BITS-1:0]          m_tdata
);

    localparam int C      = COORD_BITS;
    localparam int OFF_X1 = 0;
    localparam int OFF_Y1 = OFF_X1 + C;
    localparam int OFF_A1 = OFF_Y1 + C;
    localparam int OFF_B1 = OFF_A1 + C - 1;
    localparam int OFF_X2 = OFF_B1 + C - 1;
    localparam int OFF_Y2 = OFF_X2 + C;
    localparam int OFF_A2 = OFF_Y2 + C;
    localparam int OFF_B2 = OFF_A2 + C - 1;

    logic                 v1_reg;
    logic                 v1_next;
    logic                 k1_reg;
    logic                 k2_reg;
    logic signed [C-1:0]  x1_reg;
    logic signed [C-1:0]  y1_reg;
    logic        [C-2:0]  a1_reg;
    logic        [C-2:0]  b1_reg;
    logic signed [C-1:0]  x2_reg;
    logic signed [C-1:0]  y2_reg;
    logic        [C-2:0]  a2_reg;
    logic        [C-2:0]  b2_reg;
    logic                 ov_reg;
    logic                 ov_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic                 adv;
    logic                 take;

    logic        [C-2:0]  ex1;
    logic        [C-2:0]  ey1;
    logic        [C-2:0]  ex2;
    logic        [C-2:0]  ey2;
    logic        [C-2:0]  r1;
    logic        [C-2:0]  r2;
    logic        [C-1:0]  rad;
    logic        [2*C-1:0] rad_sq;
    logic        [2*C-1:0] gx_sq;
    logic        [2*C-1:0] gy_sq;
    logic                 gx_zero;
    logic                 gy_zero;
    logic        [2*C:0]  gap_sum;

    assign adv      = !ov_reg || m_tready;
    assign s_tready = !v1_reg || adv;
    assign take     = s_tvalid && s_tready;
    assign v1_next  = take || (v1_reg && !adv);
    assign ov_next  = adv ? v1_reg : ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            k1_reg <= s_tuser[0];
            k2_reg <= s_tuser[1];
            x1_reg <= s_tdata[OFF_X1 +: C];
            y1_reg <= s_tdata[OFF_Y1 +: C];
            a1_reg <= s_tdata[OFF_A1 +: C-1];
            b1_reg <= s_tdata[OFF_B1 +: C-1];
            x2_reg <= s_tdata[OFF_X2 +: C];
            y2_reg <= s_tdata[OFF_Y2 +: C];
            a2_reg <= s_tdata[OFF_A2 +: C-1];
            b2_reg <= s_tdata[OFF_B2 +: C-1];
        end
        if (adv)
        begin
            hit_reg <= hit_next;
        end
    end

    // circles enter the gap test as points and carry their radius instead
    always_comb
    begin
        ex1 = (k1_reg == sot_pkg::KIND_RECT) ? a1_reg : '0;
        ey1 = (k1_reg == sot_pkg::KIND_RECT) ? b1_reg : '0;
        ex2 = (k2_reg == sot_pkg::KIND_RECT) ? a2_reg : '0;
        ey2 = (k2_reg == sot_pkg::KIND_RECT) ? b2_reg : '0;
        r1  = (k1_reg == sot_pkg::KIND_CIRCLE) ? a1_reg : '0;
        r2  = (k2_reg == sot_pkg::KIND_CIRCLE) ? a2_reg : '0;
        rad = {1'b0, r1} + {1'b0, r2};
    end

    assign rad_sq = rad * rad;

    sot_axis #(
        .COORD_BITS (COORD_BITS)
    ) u_axis_x (
        .pos_a    (x1_reg),
        .len_a    (ex1),
        .pos_b    (x2_reg),
        .len_b    (ex2),
        .gap_sq   (gx_sq),
        .gap_zero (gx_zero)
    );

    sot_axis #(
        .COORD_BITS (COORD_BITS)
    ) u_axis_y (
        .pos_a    (y1_reg),
        .len_a    (ey1),
        .pos_b    (y2_reg),
        .len_b    (ey2),
        .gap_sq   (gy_sq),
        .gap_zero (gy_zero)
    );

    assign gap_sum  = {1'b0, gx_sq} + {1'b0, gy_sq};
    assign hit_next = (gap_sum <= {1'b0, rad_sq});

    assign m_tvalid = ov_reg;
    assign m_tdata  = {{(sot_pkg::RESULT_BITS-1){1'b0}}, hit_reg};

    // two rectangles carry no radius
    a_rect_no_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && k1_reg == sot_pkg::KIND_RECT && k2_reg == sot_pkg::KIND_RECT)
        |-> (rad_sq == '0))
        else $error("radius square non-zero for two rectangles");

    // touching or overlapping spans on both axes always give a hit
    a_zero_gap_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && adv && gx_zero && gy_zero) |=> (m_tvalid && m_tdata[0]))
        else $error("zero gap on both axes not reported as overlap");

    // a stalled input stage keeps its request
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !adv) |=> (v1_reg && $stable(x1_reg) && $stable(y2_reg)
                              && $stable(k1_reg) && $stable(k2_reg)))
        else $error("input stage lost its request under stall");

    // a request moving on always lands in the result register
    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && adv) |=> m_tvalid)
        else $error("request dropped between stages");

endmodule

`default_nettype wire
